// ===== rtl/brl_pkg.sv =====
// shared constants and types for the bresenham line rasterizer
`timescale 1ns / 1ps

package brl_pkg;

   // width of every coordinate field on the ports
   localparam int FIELD_BITS = 6;
   // default number of coordinate bits actually used
   localparam int COORD_BITS_DEF = 6;
   // width of the color field
   localparam int COLOR_BITS = 32;

   // sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SETUP = 3'b010,
      ST_DRAW  = 3'b100
   } state_type;

endpackage

// ===== rtl/bresenham_line_raster.sv =====
// bresenham line rasterizer: one line command in, one beat per pixel out
`timescale 1ns / 1ps

// A line command (two endpoints and a color) is taken when req_valid and
// req_ready are both high; the block then answers with one rsp beat per
// pixel of the integer Bresenham line between the endpoints, in drawing
// order, every beat carrying the command's color and the final beat having
// rsp_last_pixel set. Endpoints are reordered so that x never decreases,
// and only the low COORD_BITS bits of each coordinate are used (the output
// coordinates are zero-extended to the port width). The command is captured
// in the accept cycle, the setup state works out the deltas and the initial
// error term, then one pixel leaves per cycle as long as rsp_ready stays
// high, so a line whose longer axis spans N steps gives N + 1 pixels.
// The pixel rate is set by the single error-term adder that the sequencer
// reuses on every step. req_ready is high only while no line is being
// drawn; the last pixel may still sit in the output register when the next
// command is taken.
module bresenham_line_raster
   import brl_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FIELD_BITS-1:0] req_start_x,
   input  logic [FIELD_BITS-1:0] req_start_y,
   input  logic [FIELD_BITS-1:0] req_end_x,
   input  logic [FIELD_BITS-1:0] req_end_y,
   input  logic [COLOR_BITS-1:0] req_line_color,
   // pixel channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [FIELD_BITS-1:0] rsp_pixel_x,
   output logic [FIELD_BITS-1:0] rsp_pixel_y,
   output logic [COLOR_BITS-1:0] rsp_pixel_color,
   output logic                  rsp_last_pixel
);

   // error term needs sign plus room for twice a delta plus margin
   localparam int ERR_BITS = COORD_BITS + 3;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic signed [ERR_BITS-1:0] err_type;

   // sequencer
   state_type state_ff, state_in;

   // endpoints after ordering, captured on accept
   coord_type x1_ff, y1_ff, x2_ff, y2_ff;
   coord_type x1_in, y1_in, x2_in, y2_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   // walking state
   coord_type cur_x_ff, cur_x_in;
   coord_type cur_y_ff, cur_y_in;
   coord_type remain_ff, remain_in;
   err_type   err_ff, err_in;
   err_type   inc_keep_ff, inc_keep_in;   // added when error is negative
   err_type   inc_move_ff, inc_move_in;   // added when minor axis moves
   logic      steep_ff, steep_in;
   logic      down_ff, down_in;

   // output register, color kept apart so a new command cannot disturb it
   logic      rsp_valid_ff, rsp_valid_in;
   coord_type px_ff, px_in;
   coord_type py_ff, py_in;
   logic [COLOR_BITS-1:0] pcolor_ff, pcolor_in;
   logic      last_ff, last_in;

   // setup arithmetic
   coord_type dx, ady, maj, mnr;
   logic      neg_dy, steep;

   // shared step logic
   logic      accept, load, move_minor;
   err_type   err_add;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign load      = (state_ff == ST_DRAW) && (!rsp_valid_ff || rsp_ready);

   // deltas and octant from the ordered endpoints
   always_comb begin
      dx     = x2_ff - x1_ff;
      neg_dy = (y1_ff > y2_ff);
      ady    = neg_dy ? (y1_ff - y2_ff) : (y2_ff - y1_ff);
      steep  = (dx < ady);
      maj    = steep ? ady : dx;
      mnr    = steep ? dx : ady;
   end

   // the one error-term adder, minor axis moves on zero as well
   assign move_minor = !err_ff[ERR_BITS-1];
   assign err_add    = err_ff + (move_minor ? inc_move_ff : inc_keep_ff);

   always_comb begin
      state_in     = state_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      color_in     = color_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      remain_in    = remain_ff;
      err_in       = err_ff;
      inc_keep_in  = inc_keep_ff;
      inc_move_in  = inc_move_ff;
      steep_in     = steep_ff;
      down_in      = down_ff;
      rsp_valid_in = rsp_valid_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pcolor_in    = pcolor_ff;
      last_in      = last_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // swap whenever the line runs right to left
               if (req_start_x[COORD_BITS-1:0] > req_end_x[COORD_BITS-1:0]) begin
                  x1_in = req_end_x[COORD_BITS-1:0];
                  y1_in = req_end_y[COORD_BITS-1:0];
                  x2_in = req_start_x[COORD_BITS-1:0];
                  y2_in = req_start_y[COORD_BITS-1:0];
               end else begin
                  x1_in = req_start_x[COORD_BITS-1:0];
                  y1_in = req_start_y[COORD_BITS-1:0];
                  x2_in = req_end_x[COORD_BITS-1:0];
                  y2_in = req_end_y[COORD_BITS-1:0];
               end
               color_in = req_line_color;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cur_x_in    = x1_ff;
            cur_y_in    = y1_ff;
            remain_in   = maj;
            steep_in    = steep;
            down_in     = neg_dy;
            inc_keep_in = ERR_BITS'(mnr) <<< 1;
            inc_move_in = (ERR_BITS'(mnr) - ERR_BITS'(maj)) <<< 1;
            err_in      = (ERR_BITS'(mnr) <<< 1) - ERR_BITS'(maj);
            state_in    = ST_DRAW;
         end
         ST_DRAW: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               px_in        = cur_x_ff;
               py_in        = cur_y_ff;
               pcolor_in    = color_ff;
               last_in      = (remain_ff == '0);
               err_in       = err_add;
               remain_in    = remain_ff - 1'b1;
               if (steep_ff) begin
                  cur_y_in = down_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
                  if (move_minor) begin
                     cur_x_in = cur_x_ff + 1'b1;
                  end
               end else begin
                  cur_x_in = cur_x_ff + 1'b1;
                  if (move_minor) begin
                     cur_y_in = down_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
                  end
               end
               if (remain_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      x2_ff       <= x2_in;
      y2_ff       <= y2_in;
      color_ff    <= color_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      remain_ff   <= remain_in;
      err_ff      <= err_in;
      inc_keep_ff <= inc_keep_in;
      inc_move_ff <= inc_move_in;
      steep_ff    <= steep_in;
      down_ff     <= down_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pcolor_ff   <= pcolor_in;
      last_ff     <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = FIELD_BITS'(px_ff);
   assign rsp_pixel_y     = FIELD_BITS'(py_ff);
   assign rsp_pixel_color = pcolor_ff;
   assign rsp_last_pixel  = last_ff;

   // sequencer stays one-hot
   assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("sequencer state not one-hot");

   // a taken command always moves to the setup state, and setup to draw
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SETUP))
      else $error("command accept not followed by setup");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP) |=> (state_ff == ST_DRAW))
      else $error("setup not followed by draw");

   // a stalled pixel beat stays valid with its payload unchanged
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_pixel_color)
         && $stable(rsp_last_pixel)))
      else $error("pixel beat changed while stalled");

   // no new command while a line is still being walked
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("ready raised during a line");

endmodule

// ===== verif/tb_bresenham_line_raster.sv =====
// self-checking testbench for the bresenham line rasterizer
`timescale 1ns / 1ps

module tb_bresenham_line_raster
   import brl_pkg::*;
();

   localparam int CLK_HALF      = 4;
   localparam int RESET_CYCLES  = 6;
   localparam int RANDOM_LINES  = 410;
   // worst gap between two beats: a stalled receiver or an idle sender,
   // both geometric at 66 percent, plus setup; taken many times over
   localparam int STALL_LIMIT   = 2000;
   // longest line plus setup and output register
   localparam int DRAIN_CYCLES  = 70;
   localparam int REPORT_LIMIT  = 10;
   localparam logic [FIELD_BITS-1:0] COORD_MAX = '1;

   // one expected pixel beat
   typedef struct {
      logic [FIELD_BITS-1:0] x;
      logic [FIELD_BITS-1:0] y;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } pixel_beat_type;

   // walks each accepted line and keeps the pixels it must produce, in order
   class pixel_scoreboard;
      pixel_beat_type expected_pixels[$];
      int             mismatches;

      function new();
         mismatches = 0;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // integer bresenham walk of one line command
      function void note_line(logic [FIELD_BITS-1:0] sx, logic [FIELD_BITS-1:0] sy,
                              logic [FIELD_BITS-1:0] ex, logic [FIELD_BITS-1:0] ey,
                              logic [COLOR_BITS-1:0] color);
         int coord_mask;
         int x0, y0, x1, y1, tmp;
         int dx, dy, ady, major_len, minor_len, err, n;
         bit steep, down;
         logic [FIELD_BITS-1:0] px, py;
         pixel_beat_type beat;
         coord_mask = (1 << COORD_BITS_DEF) - 1;
         x0 = sx & coord_mask;
         y0 = sy & coord_mask;
         x1 = ex & coord_mask;
         y1 = ey & coord_mask;
         // order so x never decreases, horizontal lines included
         if (x0 > x1) begin
            tmp = x0; x0 = x1; x1 = tmp;
            tmp = y0; y0 = y1; y1 = tmp;
         end
         dx = x1 - x0;
         dy = y1 - y0;
         ady = (dy < 0) ? -dy : dy;
         down = (dy < 0);
         steep = (dx < ady);
         major_len = steep ? ady : dx;
         minor_len = steep ? dx : ady;
         err = 2 * minor_len - major_len;
         px = FIELD_BITS'(x0);
         py = FIELD_BITS'(y0);
         for (n = 0; n <= major_len; n++) begin
            beat.x = px;
            beat.y = py;
            beat.color = color;
            beat.last = (n == major_len);
            expected_pixels.push_back(beat);
            if (err < 0) begin
               err += 2 * minor_len;
            end else begin
               err += 2 * (minor_len - major_len);
               if (steep) px = px + 1'b1;
               else py = down ? py - 1'b1 : py + 1'b1;
            end
            if (steep) py = down ? py - 1'b1 : py + 1'b1;
            else px = px + 1'b1;
         end
      endfunction

      function void check_pixel(logic [FIELD_BITS-1:0] x, logic [FIELD_BITS-1:0] y,
                                logic [COLOR_BITS-1:0] color, logic last);
         pixel_beat_type want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected pixel beat x=%0d y=%0d color=%h last=%b",
                        $realtime, x, y, color, last);
            return;
         end
         want = expected_pixels.pop_front();
         if (x !== want.x || y !== want.y || color !== want.color || last !== want.last)
         begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: pixel exp %0d,%0d %h %b got %0d,%0d %h %b",
                        $realtime, want.x, want.y, want.color, want.last,
                        x, y, color, last);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [FIELD_BITS-1:0] req_start_x = '0;
   logic [FIELD_BITS-1:0] req_start_y = '0;
   logic [FIELD_BITS-1:0] req_end_x = '0;
   logic [FIELD_BITS-1:0] req_end_y = '0;
   logic [COLOR_BITS-1:0] req_line_color = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [FIELD_BITS-1:0] rsp_pixel_x;
   logic [FIELD_BITS-1:0] rsp_pixel_y;
   logic [COLOR_BITS-1:0] rsp_pixel_color;
   logic                  rsp_last_pixel;

   // percentages of cycles in which the sender idles or the receiver stalls
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int idle_cycles    = 0;

   pixel_scoreboard pixels = new;

   bresenham_line_raster uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_line_color (req_line_color),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_last_pixel (rsp_last_pixel)
   );

   always #(CLK_HALF) clock = ~clock;

   // receiver back-pressure, redrawn every cycle at the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // pixel beats are checked at the rising edge, against pre-edge values
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         pixels.check_pixel(rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_last_pixel);
   end

   // watchdog: too many cycles in a row without any beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_bresenham_line_raster NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // drive one line command; called and returning at a falling edge
   task automatic send_line(logic [FIELD_BITS-1:0] sx, logic [FIELD_BITS-1:0] sy,
                            logic [FIELD_BITS-1:0] ex, logic [FIELD_BITS-1:0] ey,
                            logic [COLOR_BITS-1:0] color);
      // random idle cycles before the beat is offered
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_start_x    <= sx;
      req_start_y    <= sy;
      req_end_x      <= ex;
      req_end_y      <= ey;
      req_line_color <= color;
      // hold until the block takes the beat
      do @(posedge clock); while (!req_ready);
      pixels.note_line(sx, sy, ex, ey, color);
      @(negedge clock);
   endtask

   function automatic logic [FIELD_BITS-1:0] near_coord(logic [FIELD_BITS-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(8)) - 4;
      if (v < 0) v = 0;
      if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
      return FIELD_BITS'(v);
   endfunction

   // random command, mostly general lines, some short ones and some
   // degenerate shapes (point, horizontal, vertical, diagonal)
   task automatic random_line();
      logic [FIELD_BITS-1:0] sx, sy, ex, ey, span;
      int pick;
      sx = FIELD_BITS'($urandom);
      sy = FIELD_BITS'($urandom);
      ex = FIELD_BITS'($urandom);
      ey = FIELD_BITS'($urandom);
      pick = $urandom_range(99);
      if (pick < 25) begin
         ex = near_coord(sx);
         ey = near_coord(sy);
      end else if (pick < 30) begin
         ex = sx;
         ey = sy;
      end else if (pick < 35) begin
         ey = sy;
      end else if (pick < 40) begin
         ex = sx;
      end else if (pick < 45) begin
         // diagonal, either slope, either direction
         span = FIELD_BITS'($urandom_range(COORD_MAX));
         sx = FIELD_BITS'($urandom_range(COORD_MAX - span));
         sy = FIELD_BITS'($urandom_range(COORD_MAX - span));
         ex = sx + span;
         ey = sy + span;
         if ($urandom_range(1)) begin
            sy = COORD_MAX - sy;
            ey = COORD_MAX - ey;
         end
         if ($urandom_range(1)) begin
            span = sx; sx = ex; ex = span;
            span = sy; sy = ey; ey = span;
         end
      end
      send_line(sx, sy, ex, ey, $urandom);
   endtask

   initial begin
      int n;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed lines, no idling
      send_line(6'd0, 6'd0, 6'd0, 6'd0, 32'h0000_0000);      // single point at origin
      send_line(6'd63, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF);  // single point at far corner
      send_line(6'd0, 6'd0, 6'd63, 6'd0, 32'h5555_5555);     // full horizontal
      send_line(6'd63, 6'd5, 6'd0, 6'd5, 32'hAAAA_AAAA);     // horizontal right to left
      send_line(6'd10, 6'd0, 6'd10, 6'd63, 32'h1234_5678);   // full vertical up
      send_line(6'd10, 6'd63, 6'd10, 6'd0, 32'h8765_4321);   // full vertical down
      send_line(6'd0, 6'd0, 6'd63, 6'd63, 32'hFF00_FF00);    // rising diagonal
      send_line(6'd0, 6'd63, 6'd63, 6'd0, 32'h00FF_00FF);    // falling diagonal
      send_line(6'd63, 6'd0, 6'd0, 6'd63, 32'hDEAD_BEEF);    // diagonal right to left
      send_line(6'd0, 6'd0, 6'd2, 6'd1, 32'h0F0F_0F0F);      // error term hits zero
      send_line(6'd0, 6'd0, 6'd1, 6'd2, 32'hF0F0_F0F0);      // steep tie
      send_line(6'd5, 6'd3, 6'd60, 6'd20, 32'hCAFE_F00D);    // shallow rising
      send_line(6'd5, 6'd40, 6'd60, 6'd22, 32'hBADC_0FFE);   // shallow falling
      send_line(6'd3, 6'd1, 6'd20, 6'd62, 32'h0123_4567);    // steep rising
      send_line(6'd20, 6'd62, 6'd3, 6'd1, 32'h89AB_CDEF);    // steep right to left
      send_line(6'd30, 6'd60, 6'd40, 6'd2, 32'h7FFF_FFFF);   // steep falling
      send_line(6'd63, 6'd0, 6'd0, 6'd1, 32'h8000_0000);     // nearly flat, swapped
      send_line(6'd0, 6'd63, 6'd63, 6'd62, 32'h0000_0001);   // nearly flat, falling
      send_line(6'd1, 6'd1, 6'd2, 6'd2, 32'hFFFF_FFFE);      // two-pixel diagonal
      send_line(6'd7, 6'd9, 6'd8, 6'd9, 32'h5A5A_A5A5);      // two-pixel horizontal

      // random lines over four back-pressure phases
      for (n = 0; n < RANDOM_LINES; n++) begin
         case ((n * 4) / RANDOM_LINES)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 66;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 66;
            end
            default: begin
               send_idle_pct  = 17;
               recv_stall_pct = 17;
            end
         endcase
         random_line();
      end
      req_valid <= 1'b0;

      // let every expected pixel arrive, then watch for strays
      while (pixels.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (pixels.mismatches == 0)
         $display("tb_bresenham_line_raster OK");
      else
         $display("tb_bresenham_line_raster NOT OK");
      $finish;
   end

endmodule
